// ----- rtl/bsa_pkg.sv -----
// ---------------------------------------------------------------------------
// bsa_pkg: shared types and constants of the bitmap slot allocator
// Command and response words, operation and status codes, and the
// fixed widths of the element index and the bitmap word.
// ---------------------------------------------------------------------------
package bsa_pkg;

    localparam int IDX_W      = 12;   // element index width
    localparam int FUNC_W     = 2;
    localparam int STATUS_W   = 2;
    localparam int RES_W      = 8;    // reserved_slots register width
    localparam int WORD_W     = 64;   // bitmap word
    localparam int WORD_SHIFT = 6;    // log2 of WORD_W

    localparam int BLOCK_SLOTS_DEF = 256;
    localparam int BLOCKS_DEF      = 16;

    localparam logic [RES_W-1:0] RES_RESET = 8'd1;

    typedef logic [FUNC_W-1:0]   t_func;
    typedef logic [STATUS_W-1:0] t_status;

    localparam t_func FUNC_ALLOC   = 2'd0;
    localparam t_func FUNC_RELEASE = 2'd1;
    localparam t_func FUNC_CLAIM   = 2'd2;

    localparam t_status ST_OK       = 2'd0;
    localparam t_status ST_OVERFLOW = 2'd1;
    localparam t_status ST_INVALID  = 2'd2;

    typedef struct packed {
        t_func            func;
        logic [IDX_W-1:0] index;
    } t_cmd;

    typedef struct packed {
        logic [IDX_W-1:0] result_index;
        t_status          status;
    } t_rsp;

endpackage

// ----- rtl/bitmap_slot_allocator.sv -----
// ---------------------------------------------------------------------------
// bitmap_slot_allocator: two-level bitmap allocator for element indices
// Allocates the lowest free index, releases or claims a given index, over a
// bitmap of BLOCKS blocks of BLOCK_SLOTS slots, with a block hint and a
// per-block word hint. The leading reserved slots of each block never go out.
// ---------------------------------------------------------------------------
//
//  channel   | signals                          | handshake
//  ----------+----------------------------------+------------------------------
//  command   | start, i_cmd (func, index)       | taken when start & !busy
//  response  | o_strobe, o_rsp (index, status)  | one cycle per strobe, no stall
//  config    | i_cfg_we, i_cfg_wdata            | written on any i_cfg_we edge
//
// Allocate holds busy while it looks up the word hint of each block in turn,
// from the block hint on, and then scans bitmap words one at a time from the
// hinted word; the bitmap RAM has a single read port. Release and claim hold
// busy through S_DIV, which splits the index into block and offset by
// comparing it with the block boundaries, then S_CHK and S_RMW, a read and a
// write of one word; an offset inside the reserved range answers from S_CHK.
// A bad function code or an out-of-range index answers without raising busy.
// The response comes on o_strobe in the same cycle that busy drops (or after accept).
// Reset: after reset the block clears the bitmap and word hints, one word a
// cycle, for BLOCKS*BLOCK_SLOTS/64 cycles (64 at the default size) with busy
// high. The receiver cannot stall the response.
// ---------------------------------------------------------------------------
module bitmap_slot_allocator #(
    parameter int BLOCK_SLOTS = bsa_pkg::BLOCK_SLOTS_DEF,
    parameter int BLOCKS      = bsa_pkg::BLOCKS_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      start,
    output logic                      busy,
    input  bsa_pkg::t_cmd             i_cmd,
    output logic                      o_strobe,
    output bsa_pkg::t_rsp             o_rsp,
    input  logic                      i_cfg_we,
    input  logic [bsa_pkg::RES_W-1:0] i_cfg_wdata
);

    import bsa_pkg::*;

    localparam int WPB         = BLOCK_SLOTS / WORD_W;          // words per block
    localparam int TOTAL_WORDS = BLOCKS * WPB;
    localparam int TOTAL_SLOTS = BLOCKS * BLOCK_SLOTS;
    localparam int AW  = (TOTAL_WORDS > 1) ? $clog2(TOTAL_WORDS) : 1;
    localparam int BW  = (BLOCKS > 1) ? $clog2(BLOCKS) : 1;
    localparam int HW  = $clog2(WPB + 1);                       // hint, WPB means full
    localparam int SW  = $clog2(TOTAL_SLOTS);
    localparam int TSW = (SW + 1 > IDX_W) ? SW + 1 : IDX_W;
    localparam int MW  = (HW + WORD_SHIFT + 1 > RES_W + 1) ? HW + WORD_SHIFT + 1 : RES_W + 1;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_CHK,
        S_HINT,
        S_WORD,
        S_RMW
    } t_state;

    // Reserved bits of word w within a block.
    function automatic logic [WORD_W-1:0] rmask(input logic [HW-1:0] w,
                                                input logic [RES_W-1:0] res);
        logic [MW-1:0] lo;
        logic [MW-1:0] rs;
        logic [MW-1:0] diff;
        lo   = MW'({w, {WORD_SHIFT{1'b0}}});
        rs   = MW'(res);
        diff = rs - lo;
        if (rs <= lo) begin
            rmask = '0;
        end else if (rs >= lo + MW'(WORD_W)) begin
            rmask = '1;
        end else begin
            rmask = (WORD_W'(1) << diff[WORD_SHIFT-1:0]) - WORD_W'(1);
        end
    endfunction

    // State and registers
    t_state               r_state, n_state;
    t_func                r_func, n_func;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [IDX_W-1:0]     r_rem, n_rem;
    logic [BW-1:0]        r_blk, n_blk;
    logic [AW-1:0]        r_wbase, n_wbase;
    logic [SW-1:0]        r_sbase, n_sbase;
    logic [HW-1:0]        r_w, n_w;
    logic [BW-1:0]        r_fbh, n_fbh;
    logic [AW-1:0]        r_fbh_wbase, n_fbh_wbase;
    logic [SW-1:0]        r_fbh_sbase, n_fbh_sbase;
    logic [AW-1:0]        r_clr, n_clr;
    logic [RES_W-1:0]     r_res, n_res;
    logic                 r_strobe, n_strobe;
    t_rsp                 r_rsp, n_rsp;

    // RAM ports
    logic                 w_bits_we;
    logic [AW-1:0]        w_bits_waddr;
    logic [WORD_W-1:0]    w_bits_wdata;
    logic [AW-1:0]        w_bits_raddr;
    logic [WORD_W-1:0]    w_bits_rdata;
    logic                 w_hint_we;
    logic [BW-1:0]        w_hint_waddr;
    logic [HW-1:0]        w_hint_wdata;
    logic [HW-1:0]        w_hint_rdata;

    // Word scan datapath
    logic [WORD_W-1:0]    w_eff;
    logic [WORD_W-1:0]    w_oh;
    logic [WORD_W-1:0]    w_set;
    logic [WORD_SHIFT-1:0] w_bit;
    logic [SW-1:0]        w_slot;
    logic [AW-1:0]        w_cur_addr;
    logic [WORD_W-1:0]    w_bitv;
    logic                 w_last_blk;

    // Index split
    logic [BW-1:0]        w_dq_blk;
    logic [AW-1:0]        w_dq_wbase;
    logic [SW-1:0]        w_dq_sbase;

    bsa_ram #(.WIDTH(WORD_W), .DEPTH(TOTAL_WORDS)) u_bits (
        .i_clk   (i_clk),
        .i_we    (w_bits_we),
        .i_waddr (w_bits_waddr),
        .i_wdata (w_bits_wdata),
        .i_raddr (w_bits_raddr),
        .o_rdata (w_bits_rdata)
    );

    bsa_ram #(.WIDTH(HW), .DEPTH(BLOCKS)) u_hint (
        .i_clk   (i_clk),
        .i_we    (w_hint_we),
        .i_waddr (w_hint_waddr),
        .i_wdata (w_hint_wdata),
        .i_raddr (n_blk),
        .o_rdata (w_hint_rdata)
    );

    // Read the next word as it is chosen, so its data is there the cycle after.
    assign w_bits_raddr = n_wbase + AW'(n_w);
    assign w_cur_addr   = r_wbase + AW'(r_w);

    // Lowest free bit of the current word: reserved bits count as used.
    assign w_eff  = w_bits_rdata | rmask(r_w, r_res);
    assign w_oh   = ~w_eff & (w_eff + WORD_W'(1));
    assign w_set  = w_eff | w_oh;
    assign w_slot = r_sbase + SW'({r_w, {WORD_SHIFT{1'b0}}}) + SW'(w_bit);
    assign w_bitv = WORD_W'(1) << r_rem[WORD_SHIFT-1:0];

    always_comb begin
        w_bit = '0;
        for (int k = 0; k < WORD_W; k++) begin
            if (w_oh[k]) begin
                w_bit = w_bit | WORD_SHIFT'(k);
            end
        end
    end

    // Split the index into block and offset: compare it with every block
    // boundary and keep the highest boundary it reaches.
    always_comb begin
        w_dq_blk   = '0;
        w_dq_wbase = '0;
        w_dq_sbase = '0;
        for (int k = 1; k < BLOCKS; k++) begin
            if (TSW'(r_idx) >= TSW'(k * BLOCK_SLOTS)) begin
                w_dq_blk   = BW'(k);
                w_dq_wbase = AW'(k * WPB);
                w_dq_sbase = SW'(k * BLOCK_SLOTS);
            end
        end
    end

    assign w_last_blk = (r_blk == BW'(BLOCKS - 1));

    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_idx       = r_idx;
        n_rem       = r_rem;
        n_blk       = r_blk;
        n_wbase     = r_wbase;
        n_sbase     = r_sbase;
        n_w         = r_w;
        n_fbh       = r_fbh;
        n_fbh_wbase = r_fbh_wbase;
        n_fbh_sbase = r_fbh_sbase;
        n_clr       = r_clr;
        n_res       = i_cfg_we ? i_cfg_wdata : r_res;
        n_strobe    = 1'b0;
        n_rsp       = r_rsp;

        w_bits_we    = 1'b0;
        w_bits_waddr = w_cur_addr;
        w_bits_wdata = w_bits_rdata;
        w_hint_we    = 1'b0;
        w_hint_waddr = r_blk;
        w_hint_wdata = r_w;

        case (r_state)
            S_CLEAR: begin
                // Zero one bitmap word a cycle, and one word hint while hints remain.
                w_bits_we    = 1'b1;
                w_bits_waddr = r_clr;
                w_bits_wdata = '0;
                w_hint_we    = ({1'b0, r_clr} < (AW + 1)'(BLOCKS));
                w_hint_waddr = BW'(r_clr);
                w_hint_wdata = '0;
                n_clr        = r_clr + AW'(1);
                if (r_clr == AW'(TOTAL_WORDS - 1)) begin
                    n_state = S_IDLE;
                end
            end

            S_IDLE: begin
                if (start) begin
                    n_func = i_cmd.func;
                    n_idx  = i_cmd.index;
                    if (i_cmd.func == FUNC_ALLOC) begin
                        // Start the scan at the lowest block that may have room.
                        n_blk   = r_fbh;
                        n_wbase = r_fbh_wbase;
                        n_sbase = r_fbh_sbase;
                        n_state = S_HINT;
                    end else if (i_cmd.func != FUNC_RELEASE && i_cmd.func != FUNC_CLAIM ||
                                 TSW'(i_cmd.index) >= TSW'(TOTAL_SLOTS)) begin
                        n_strobe = 1'b1;
                        n_rsp    = '{result_index: '0, status: ST_INVALID};
                    end else begin
                        n_state = S_DIV;
                    end
                end
            end

            S_DIV: begin
                // Take block, bases and offset from the boundary compare.
                n_blk   = w_dq_blk;
                n_wbase = w_dq_wbase;
                n_sbase = w_dq_sbase;
                n_rem   = r_idx - IDX_W'(w_dq_sbase);
                n_state = S_CHK;
            end

            S_CHK: begin
                // Remainder is the offset within the block.
                if (r_rem < IDX_W'(r_res)) begin
                    n_strobe = 1'b1;
                    n_rsp    = '{result_index: '0, status: ST_INVALID};
                    n_state  = S_IDLE;
                end else begin
                    n_w     = HW'(r_rem >> WORD_SHIFT);
                    n_state = S_RMW;
                end
            end

            S_RMW: begin
                w_bits_we = 1'b1;
                if (r_func == FUNC_RELEASE) begin
                    // Clear the bit and lower both hints.
                    w_bits_wdata = w_bits_rdata & ~w_bitv;
                    w_hint_we    = (w_hint_rdata > r_w);
                    if (r_fbh > r_blk) begin
                        n_fbh       = r_blk;
                        n_fbh_wbase = r_wbase;
                        n_fbh_sbase = r_sbase;
                    end
                end else begin
                    w_bits_wdata = w_bits_rdata | w_bitv;
                end
                n_strobe = 1'b1;
                n_rsp    = '{result_index: r_idx, status: ST_OK};
                n_state  = S_IDLE;
            end

            S_HINT: begin
                if (w_hint_rdata >= HW'(WPB)) begin
                    // Block full: advance to the next one, or give up.
                    if (w_last_blk) begin
                        n_strobe = 1'b1;
                        n_rsp    = '{result_index: '0, status: ST_OVERFLOW};
                        n_state  = S_IDLE;
                    end else begin
                        n_blk   = r_blk + BW'(1);
                        n_wbase = r_wbase + AW'(WPB);
                        n_sbase = r_sbase + SW'(BLOCK_SLOTS);
                    end
                end else begin
                    n_w     = w_hint_rdata;
                    n_state = S_WORD;
                end
            end

            S_WORD: begin
                if (&w_eff) begin
                    if (r_w == HW'(WPB - 1)) begin
                        if (w_last_blk) begin
                            n_strobe = 1'b1;
                            n_rsp    = '{result_index: '0, status: ST_OVERFLOW};
                            n_state  = S_IDLE;
                        end else begin
                            n_blk   = r_blk + BW'(1);
                            n_wbase = r_wbase + AW'(WPB);
                            n_sbase = r_sbase + SW'(BLOCK_SLOTS);
                            n_state = S_HINT;
                        end
                    end else begin
                        n_w = r_w + HW'(1);
                    end
                end else begin
                    // Take the lowest free bit; move the word hint past a full word.
                    w_bits_we    = 1'b1;
                    w_bits_wdata = w_bits_rdata | w_oh;
                    w_hint_we    = 1'b1;
                    w_hint_wdata = (&w_set) ? r_w + HW'(1) : r_w;
                    n_fbh        = r_blk;
                    n_fbh_wbase  = r_wbase;
                    n_fbh_sbase  = r_sbase;
                    n_strobe     = 1'b1;
                    n_rsp        = '{result_index: IDX_W'(w_slot), status: ST_OK};
                    n_state      = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_fbh       <= '0;
            r_fbh_wbase <= '0;
            r_fbh_sbase <= '0;
            r_res       <= RES_RESET;
            r_strobe    <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_clr       <= n_clr;
            r_fbh       <= n_fbh;
            r_fbh_wbase <= n_fbh_wbase;
            r_fbh_sbase <= n_fbh_sbase;
            r_res       <= n_res;
            r_strobe    <= n_strobe;
        end
        r_func  <= n_func;
        r_idx   <= n_idx;
        r_rem   <= n_rem;
        r_blk   <= n_blk;
        r_wbase <= n_wbase;
        r_sbase <= n_sbase;
        r_w     <= n_w;
        r_rsp   <= n_rsp;
    end

    assign busy     = (r_state != S_IDLE);
    assign o_strobe = r_strobe;
    assign o_rsp    = r_rsp;

endmodule

// ----- rtl/bsa_ram.sv -----
// ---------------------------------------------------------------------------
// bsa_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ---------------------------------------------------------------------------
module bsa_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        r_rdata <= mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
